@@ hdl/assert_macros.svh @@
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle assertion failed");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle assertion failed");

`endif

@@ hdl/lmts_pkg.sv @@
// Package: widths, register indexes and shared types of the template SAD block.
`default_nettype none
package lmts_pkg;

  localparam int LUMA_W        = 10;
  localparam int CHROMA_W      = 10;
  localparam int GAIN_W        = 16;
  localparam int SHIFT_W       = 5;
  localparam int OFFSET_W      = 16;
  localparam int THRESH_W      = 10;
  localparam int COUNT_W       = 2;
  localparam int PRED_W        = 16;
  localparam int SAD_W         = 24;
  localparam int PROD_W        = GAIN_W + LUMA_W + 1;
  localparam int DIFF_W        = PRED_W + 2;
  localparam int AD_W          = PRED_W + 1;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;

  localparam logic [SAD_W-1:0]   SAD_MAX    = {SAD_W{1'b1}};
  localparam logic [COUNT_W-1:0] TWO_MODELS = COUNT_W'(2);
  localparam logic [COUNT_W-1:0] ONE_MODEL  = COUNT_W'(1);

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_MODEL_COUNT    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MODEL0_GAIN    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_MODEL0_SHIFT   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_MODEL0_OFFSET  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_MODEL1_GAIN    = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_MODEL1_SHIFT   = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_MODEL1_OFFSET  = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_LUMA_THRESHOLD = CFG_IDX_W'(7);

  typedef struct packed {
    logic [COUNT_W-1:0]         model_count;
    logic signed [GAIN_W-1:0]   model0_gain;
    logic [SHIFT_W-1:0]         model0_shift;
    logic signed [OFFSET_W-1:0] model0_offset;
    logic signed [GAIN_W-1:0]   model1_gain;
    logic [SHIFT_W-1:0]         model1_shift;
    logic signed [OFFSET_W-1:0] model1_offset;
    logic [THRESH_W-1:0]        luma_threshold;
  } model_cfg_t;

  // Prediction stage to accumulator
  typedef struct packed {
    logic signed [PRED_W-1:0] pred;
    logic [AD_W-1:0]          abs_diff;
    logic                     last;
  } pred_item_t;

  // Accumulator status seen by the top level
  typedef struct packed {
    logic             load;
    logic             last;
    logic [SAD_W-1:0] acc;
  } sad_status_t;

endpackage
`default_nettype wire

@@ hdl/lmts_in_if.sv @@
// Input channel: one template sample pair per transfer.
`default_nettype none
interface lmts_in_if;
  logic                          valid;
  logic                          ready;
  logic [lmts_pkg::LUMA_W-1:0]   luma_sample;
  logic [lmts_pkg::CHROMA_W-1:0] reco_chroma;
  logic                          last_sample;

  modport source (output valid, output luma_sample, output reco_chroma,
                  output last_sample, input ready);
  modport sink   (input valid, input luma_sample, input reco_chroma,
                  input last_sample, output ready);
endinterface
`default_nettype wire

@@ hdl/lmts_out_if.sv @@
// Output channel: prediction and running SAD per transfer.
`default_nettype none
interface lmts_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [lmts_pkg::PRED_W-1:0] pred_chroma;
  logic [lmts_pkg::SAD_W-1:0]        running_sad;
  logic                              sad_final;

  modport source (output valid, output pred_chroma, output running_sad,
                  output sad_final, input ready);
  modport sink   (input valid, input pred_chroma, input running_sad,
                  input sad_final, output ready);
endinterface
`default_nettype wire

@@ hdl/lmts_cfg_regs.sv @@
// Configuration register file for the two linear models.
`default_nettype none
module lmts_cfg_regs (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [lmts_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lmts_pkg::CFG_DATA_W-1:0]   cfg_data,
  output lmts_pkg::model_cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.model_count    <= lmts_pkg::ONE_MODEL;
      cfg.model0_gain    <= '0;
      cfg.model0_shift   <= '0;
      cfg.model0_offset  <= '0;
      cfg.model1_gain    <= '0;
      cfg.model1_shift   <= '0;
      cfg.model1_offset  <= '0;
      cfg.luma_threshold <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        lmts_pkg::REG_MODEL_COUNT:
          cfg.model_count <= cfg_data[lmts_pkg::COUNT_W-1:0];
        lmts_pkg::REG_MODEL0_GAIN:
          cfg.model0_gain <= $signed(cfg_data[lmts_pkg::GAIN_W-1:0]);
        lmts_pkg::REG_MODEL0_SHIFT:
          cfg.model0_shift <= cfg_data[lmts_pkg::SHIFT_W-1:0];
        lmts_pkg::REG_MODEL0_OFFSET:
          cfg.model0_offset <= $signed(cfg_data[lmts_pkg::OFFSET_W-1:0]);
        lmts_pkg::REG_MODEL1_GAIN:
          cfg.model1_gain <= $signed(cfg_data[lmts_pkg::GAIN_W-1:0]);
        lmts_pkg::REG_MODEL1_SHIFT:
          cfg.model1_shift <= cfg_data[lmts_pkg::SHIFT_W-1:0];
        lmts_pkg::REG_MODEL1_OFFSET:
          cfg.model1_offset <= $signed(cfg_data[lmts_pkg::OFFSET_W-1:0]);
        lmts_pkg::REG_LUMA_THRESHOLD:
          cfg.luma_threshold <= cfg_data[lmts_pkg::THRESH_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hdl/lmts_predict.sv @@
// Prediction pipeline: input register, model select and multiply, shift/offset/abs-diff.
`default_nettype none
module lmts_predict (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire lmts_pkg::model_cfg_t cfg,
  lmts_in_if.sink                   sample_in,
  output logic                      item_valid,
  input  wire logic                 item_ready,
  output lmts_pkg::pred_item_t      item
);

  // Stage 1: input register
  logic                          v1;
  logic [lmts_pkg::LUMA_W-1:0]   luma1;
  logic [lmts_pkg::CHROMA_W-1:0] reco1;
  logic                          last1;

  // Stage 2: product and selected model terms
  logic                               v2;
  logic signed [lmts_pkg::PROD_W-1:0] prod2;
  logic [lmts_pkg::SHIFT_W-1:0]       shift2;
  logic signed [lmts_pkg::OFFSET_W-1:0] offset2;
  logic [lmts_pkg::CHROMA_W-1:0]      reco2;
  logic                               last2;

  logic rdy1, rdy2, rdy3;

  logic                                 use1;
  logic signed [lmts_pkg::GAIN_W-1:0]   gain_sel;
  logic signed [lmts_pkg::PROD_W-1:0]   prod_next;
  logic signed [lmts_pkg::PROD_W-1:0]   shifted;
  logic signed [lmts_pkg::PRED_W-1:0]   pred_next;
  logic signed [lmts_pkg::DIFF_W-1:0]   diff;
  logic [lmts_pkg::DIFF_W-1:0]          abs_wide;

  assign rdy3            = !item_valid || item_ready;
  assign rdy2            = !v2 || rdy3;
  assign rdy1            = !v1 || rdy2;
  assign sample_in.ready = rdy1;

  // Model one only with two models and luma strictly above threshold
  assign use1 = (cfg.model_count == lmts_pkg::TWO_MODELS)
             && (luma1 > cfg.luma_threshold);
  assign gain_sel  = use1 ? cfg.model1_gain : cfg.model0_gain;
  assign prod_next = lmts_pkg::PROD_W'(gain_sel * $signed({1'b0, luma1}));

  // Floor shift, then 16-bit wrap on the offset add
  assign shifted   = prod2 >>> shift2;
  assign pred_next = shifted[lmts_pkg::PRED_W-1:0] + offset2;
  assign diff      = $signed({{(lmts_pkg::DIFF_W-lmts_pkg::CHROMA_W){1'b0}}, reco2})
                   - lmts_pkg::DIFF_W'(pred_next);
  assign abs_wide  = diff[lmts_pkg::DIFF_W-1] ? lmts_pkg::DIFF_W'(-diff)
                                              : lmts_pkg::DIFF_W'(diff);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1         <= 1'b0;
      v2         <= 1'b0;
      item_valid <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= sample_in.valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        item_valid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && sample_in.valid) begin
      luma1 <= sample_in.luma_sample;
      reco1 <= sample_in.reco_chroma;
      last1 <= sample_in.last_sample;
    end
    if (rdy2 && v1) begin
      prod2   <= prod_next;
      shift2  <= use1 ? cfg.model1_shift : cfg.model0_shift;
      offset2 <= use1 ? cfg.model1_offset : cfg.model0_offset;
      reco2   <= reco1;
      last2   <= last1;
    end
    if (rdy3 && v2) begin
      item.pred     <= pred_next;
      item.abs_diff <= abs_wide[lmts_pkg::AD_W-1:0];
      item.last     <= last2;
    end
  end

endmodule
`default_nettype wire

@@ hdl/lmts_sad_acc.sv @@
// Saturating SAD accumulator and result register.
`default_nettype none
module lmts_sad_acc (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  output logic                     item_ready,
  input  wire lmts_pkg::pred_item_t item,
  lmts_out_if.source               result_out,
  output lmts_pkg::sad_status_t    status
);

  logic [lmts_pkg::SAD_W-1:0] acc;
  logic [lmts_pkg::SAD_W:0]   sum_wide;
  logic [lmts_pkg::SAD_W-1:0] acc_next;
  logic                       load;

  assign item_ready = !result_out.valid || result_out.ready;
  assign load       = item_valid && item_ready;

  assign sum_wide = {1'b0, acc} + (lmts_pkg::SAD_W + 1)'(item.abs_diff);
  assign acc_next = sum_wide[lmts_pkg::SAD_W] ? lmts_pkg::SAD_MAX
                                              : sum_wide[lmts_pkg::SAD_W-1:0];

  assign status.load = load;
  assign status.last = item.last;
  assign status.acc  = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc              <= '0;
      result_out.valid <= 1'b0;
    end else begin
      if (item_ready) begin
        result_out.valid <= item_valid;
      end
      if (load) begin
        acc <= item.last ? '0 : acc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_out.pred_chroma <= item.pred;
      result_out.running_sad <= acc_next;
      result_out.sad_final   <= item.last;
    end
  end

endmodule
`default_nettype wire

@@ hdl/linear_model_template_sad.sv @@
// Top level: linear-model template SAD over a stream of template samples.
//
//  channel     dir  payload                                     handshake
//  sample_in   in   luma_sample, reco_chroma, last_sample       valid/ready
//  result_out  out  pred_chroma, running_sad, sad_final         valid/ready
//  cfg         in   cfg_index, cfg_data                         cfg_we only
//
// One sample per cycle sustained while the output accepts results; the result is
// registered in turn by the input, multiply, shift/offset/abs-diff and accumulate/result regs.
// Ready flows back stage by stage, so bubbles are squeezed out and a new
// sample is taken while a finished result still waits at the output.
// The running SAD is a saturating add that feeds back into the accumulator in the last stage.
// Synchronous reset clears all valids and the SAD; model count resets to one.
`default_nettype none
`include "assert_macros.svh"
module linear_model_template_sad (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [lmts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lmts_pkg::CFG_DATA_W-1:0] cfg_data,
  lmts_in_if.sink                              sample_in,
  lmts_out_if.source                           result_out
);

  lmts_pkg::model_cfg_t  cfg;
  lmts_pkg::pred_item_t  item;
  lmts_pkg::sad_status_t status;
  logic                  item_valid;
  logic                  item_ready;

  // Model registers; the user must write them only while the pipeline is empty (not enforced here)
  lmts_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register, model multiply, prediction and absolute difference
  lmts_predict u_predict (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .sample_in  (sample_in),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  // Running SAD and result register
  lmts_sad_acc u_acc (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .result_out (result_out),
    .status     (status)
  );

  // SAD restarts at zero after the last sample of a block
  `ASSERT_NEXT(a_sad_clears, clk, rst, status.load && status.last, status.acc == '0)
  // Saturating add never wraps below the previous total
  `ASSERT_NEXT(a_sad_no_wrap, clk, rst, status.load, result_out.running_sad >= $past(status.acc))
  // Stalls only come from the output side
  `ASSERT_IMPL(a_stall_source, clk, rst, !sample_in.ready, result_out.valid && !result_out.ready)

endmodule
`default_nettype wire
